/* rtl/mf3_pkg.sv */
// Package for the 3x3 median filter: widths, register indexes, item control
// struct and the compare helpers used by the sorting stages.
// Depends on nothing; every other file of the block but mf3_ram imports it.
package mf3_pkg;

   localparam int MAX_WIDTH      = 2048;
   localparam int PIX_BITS       = 8;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = 16;
   localparam int WIDTH_REG_BITS = 12;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   // Result slots one pixel can cause, in output order.
   localparam int EMIT_CUR       = 0;  // (x-1, y-1), the window result
   localparam int EMIT_CUR_EDGE  = 1;  // (W-1, y-1), right border of the row above
   localparam int EMIT_LAST      = 2;  // (x-1, y), bottom border row
   localparam int EMIT_LAST_EDGE = 3;  // (W-1, y), last pixel of the frame
   localparam int EMIT_COUNT     = 4;

   typedef logic [PIX_BITS-1:0] pix_type;
   typedef pix_type [2:0] win_col_type;   // index 0 top row, 2 bottom row
   typedef win_col_type [2:0] win_type;   // index 0 oldest column

   typedef struct packed {
      logic [EMIT_COUNT-1:0] emit;
      logic                  interior;
      logic [COL_BITS-1:0]   prev_col;
      logic [COL_BITS-1:0]   last_col;
      logic [ROW_BITS-1:0]   prev_row;
      logic [ROW_BITS-1:0]   row;
   } item_ctrl_type;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

/* rtl/mf3_req_if.sv */
// Input channel of the median filter: one pixel per item.
// Depends on mf3_pkg for the pixel width.
interface mf3_req_if
   import mf3_pkg::*;
();
   logic    valid;
   logic    ready;
   pix_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

/* rtl/mf3_rsp_if.sv */
// Result channel of the median filter: one result pixel with position and flags.
// Depends on mf3_pkg for the field widths.
interface mf3_rsp_if
   import mf3_pkg::*;
();
   logic                valid;
   logic                ready;
   pix_type             median;
   logic [COL_BITS-1:0] out_col;
   logic [ROW_BITS-1:0] out_row;
   logic                last;
   logic                frame_end;

   modport source (output valid, output median, output out_col, output out_row,
                   output last, output frame_end, input ready);
   modport sink   (input valid, input median, input out_col, input out_row,
                   input last, input frame_end, output ready);
endinterface

/* rtl/mf3_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents. No dependencies.
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/mf3_line_window.sv */
// Front end of the median filter: frame position, size registers, the two line
// RAMs with their read-modify-write and forwarding, and the 3x3 window.
// Depends on mf3_pkg and mf3_ram.
module mf3_line_window
   import mf3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   input  pix_type                   req_pixel,
   input  logic                      pipe_en,
   output logic                      win_valid,
   output win_type                   win,
   output item_ctrl_type             win_ctrl
);
   logic [COL_BITS-1:0]       col_ff, col_in, last_col_ff, last_col_in;
   logic [ROW_BITS-1:0]       row_ff, row_in, last_row_ff, last_row_in;
   logic [WIDTH_REG_BITS-1:0] width_val;
   logic                      restart, accept, row_end, last_row;
   item_ctrl_type             item_ctrl;

   logic                s1_valid_ff, s1_fwd_ff;
   pix_type             s1_px_ff;
   logic [COL_BITS-1:0] s1_x_ff;
   item_ctrl_type       s1_ctrl_ff;

   pix_type       ram_a_q, ram_b_q, line_a, line_b, wr_a_ff, wr_b_ff;
   logic          wr_en;
   win_type       win_ff;
   logic          win_valid_ff;
   item_ctrl_type win_ctrl_ff;

   // Size registers hold the last column and last row of the effective frame.
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      restart     = 1'b0;
      width_val   = csr_wdata[WIDTH_REG_BITS-1:0];
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               restart = 1'b1;
               if (width_val == '0) begin
                  last_col_in = '0;
               end else if (32'(width_val) > 32'(MAX_WIDTH)) begin
                  last_col_in = COL_BITS'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_BITS'(width_val - 1'b1);
               end
            end
            REG_IMAGE_HEIGHT: begin
               restart = 1'b1;
               if (csr_wdata == '0) begin
                  last_row_in = '0;
               end else begin
                  last_row_in = ROW_BITS'(csr_wdata - 1'b1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign accept   = req_valid && pipe_en;
   assign row_end  = (col_ff == last_col_ff);
   assign last_row = (row_ff == last_row_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : ROW_BITS'(row_ff + 1'b1);
         end else begin
            col_in = COL_BITS'(col_ff + 1'b1);
         end
      end
   end

   // Which results this pixel causes, worked out while its line data is read.
   always_comb begin
      item_ctrl                      = '0;
      item_ctrl.emit[EMIT_CUR]       = (row_ff != '0) && (col_ff != '0);
      item_ctrl.emit[EMIT_CUR_EDGE]  = (row_ff != '0) && row_end;
      item_ctrl.emit[EMIT_LAST]      = last_row && (col_ff != '0);
      item_ctrl.emit[EMIT_LAST_EDGE] = last_row && row_end;
      item_ctrl.interior = (col_ff[COL_BITS-1:1] != '0) && (row_ff[ROW_BITS-1:1] != '0);
      item_ctrl.prev_col = COL_BITS'(col_ff - 1'b1);
      item_ctrl.last_col = last_col_ff;
      item_ctrl.prev_row = ROW_BITS'(row_ff - 1'b1);
      item_ctrl.row      = row_ff;
   end

   // Line A holds the row above, line B the row above that.
   assign line_a = s1_fwd_ff ? wr_a_ff : ram_a_q;
   assign line_b = s1_fwd_ff ? wr_b_ff : ram_b_q;
   assign wr_en  = s1_valid_ff && pipe_en;

   mf3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_x_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_a_q)
   );

   mf3_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_x_ff),
      .wr_data (line_a),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_b_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         last_col_ff  <= COL_BITS'(RESET_WIDTH - 1);
         last_row_ff  <= ROW_BITS'(RESET_HEIGHT - 1);
         s1_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         if (pipe_en) begin
            s1_valid_ff  <= accept;
            win_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_pixel;
         s1_x_ff    <= col_ff;
         // The item ahead writes this same entry at the edge this read happens.
         s1_fwd_ff  <= s1_valid_ff && (s1_x_ff == col_ff);
         s1_ctrl_ff <= item_ctrl;
      end
      if (wr_en) begin
         wr_a_ff      <= s1_px_ff;
         wr_b_ff      <= line_a;
         win_ff[0]    <= win_ff[1];
         win_ff[1]    <= win_ff[2];
         win_ff[2][0] <= line_b;
         win_ff[2][1] <= line_a;
         win_ff[2][2] <= s1_px_ff;
         win_ctrl_ff  <= s1_ctrl_ff;
      end
   end

   assign win_valid = win_valid_ff;
   assign win       = win_ff;
   assign win_ctrl  = win_ctrl_ff;

   a_fwd_single_column: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_fwd_ff |-> last_col_ff == '0)
      else $error("line forwarding used with more than one column");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff)
      else $error("column position beyond the row");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= last_row_ff)
      else $error("row position beyond the frame");
endmodule

/* rtl/mf3_median_sort.sv */
// Three-stage median of the 3x3 window: sort each column, then take the max of
// the lows, median of the middles and min of the highs, then their median.
// Depends on mf3_pkg.
module mf3_median_sort
   import mf3_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pipe_en,
   input  logic          in_valid,
   input  win_type       win,
   input  item_ctrl_type in_ctrl,
   output logic          out_valid,
   output pix_type       med,
   output item_ctrl_type out_ctrl
);
   pix_type [2:0] lo_in, mid_in, hi_in, lo_ff, mid_ff, hi_ff;
   pix_type       max_lo_ff, med_mid_ff, min_hi_ff, med_ff;
   logic          va_ff, vb_ff, vc_ff;
   item_ctrl_type ca_ff, cb_ff, cc_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         lo_in[c]  = min2(min2(win[c][0], win[c][1]), win[c][2]);
         mid_in[c] = med3(win[c][0], win[c][1], win[c][2]);
         hi_in[c]  = max2(max2(win[c][0], win[c][1]), win[c][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (pipe_en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lo_ff      <= lo_in;
         mid_ff     <= mid_in;
         hi_ff      <= hi_in;
         ca_ff      <= in_ctrl;
         max_lo_ff  <= max2(max2(lo_ff[0], lo_ff[1]), lo_ff[2]);
         med_mid_ff <= med3(mid_ff[0], mid_ff[1], mid_ff[2]);
         min_hi_ff  <= min2(min2(hi_ff[0], hi_ff[1]), hi_ff[2]);
         cb_ff      <= ca_ff;
         med_ff     <= med3(max_lo_ff, med_mid_ff, min_hi_ff);
         cc_ff      <= cb_ff;
      end
   end

   assign out_valid = vc_ff;
   assign med       = med_ff;
   assign out_ctrl  = cc_ff;
endmodule

/* rtl/mf3_result_seq.sv */
// Result sequencer: holds one item and hands out its zero to four results in
// order, one per accepted output cycle; its readiness stalls the pipeline.
// Depends on mf3_pkg.
module mf3_result_seq
   import mf3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  pix_type             in_med,
   input  item_ctrl_type       in_ctrl,
   output logic                pipe_en,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pix_type             rsp_median,
   output logic [COL_BITS-1:0] rsp_out_col,
   output logic [ROW_BITS-1:0] rsp_out_row,
   output logic                rsp_last,
   output logic                rsp_frame_end
);
   logic [EMIT_COUNT-1:0] pend_ff, pend_in;
   pix_type               med_ff;
   item_ctrl_type         ctrl_ff;
   logic                  single, take;

   assign single    = ((pend_ff & (pend_ff - 1'b1)) == '0);
   assign rsp_valid = (pend_ff != '0);
   assign take      = !rsp_valid || (single && rsp_ready);
   assign pipe_en   = take;

   always_comb begin
      pend_in = pend_ff;
      if (take) begin
         pend_in = in_valid ? in_ctrl.emit : '0;
      end else if (rsp_ready) begin
         pend_in = pend_ff & (pend_ff - 1'b1);
      end
   end

   always_comb begin
      rsp_median  = '0;
      rsp_out_col = ctrl_ff.last_col;
      rsp_out_row = ctrl_ff.row;
      if (pend_ff[EMIT_CUR]) begin
         rsp_median  = ctrl_ff.interior ? med_ff : '0;
         rsp_out_col = ctrl_ff.prev_col;
         rsp_out_row = ctrl_ff.prev_row;
      end else if (pend_ff[EMIT_CUR_EDGE]) begin
         rsp_out_row = ctrl_ff.prev_row;
      end else if (pend_ff[EMIT_LAST]) begin
         rsp_out_col = ctrl_ff.prev_col;
      end
      rsp_last      = single;
      rsp_frame_end = single && pend_ff[EMIT_LAST_EDGE];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         med_ff  <= in_med;
         ctrl_ff <= in_ctrl;
      end
   end

   a_stall_holds_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pend_ff))
      else $error("pending results changed while the output was stalled");

   a_frame_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last && rsp_out_col == ctrl_ff.last_col)
      else $error("frame end flagged away from the last result of the frame");
endmodule

/* rtl/median_filter_3x3.sv */
// Top level of the 3x3 median filter over a raster-order 8-bit pixel stream.
// Depends on mf3_pkg, mf3_req_if, mf3_rsp_if, mf3_line_window,
// mf3_median_sort and mf3_result_seq.
//
//   Channel    Direction  Handshake          Contents
//   req_chan   in         valid/ready        pixel, 8 bits, raster order
//   rsp_chan   out        valid/ready        median, out_col, out_row, last, frame_end
//   csr_*      in         write enable only  index 0 image_width, 1 image_height
//
// The block takes one pixel per clock unless the result side stalls it. A pixel
// causes one result in the body of the frame, two at the end of a row and up to
// four on the last row; the single result port hands out one result per clock
// while it is ready, so those extra results hold off input. The line RAM read of
// a pixel happens on the edge that accepts it; then come the window, three sort
// stages and the result register before its first result is presented.
// Reset is synchronous and active high; no memory clearing pass follows it.
// A stalled result port stops the whole pipeline at once, so no item is dropped.

module median_filter_3x3
   import mf3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   mf3_req_if.sink                   req_chan,
   mf3_rsp_if.source                 rsp_chan
);
   // One enable advances every stage; it comes from the result sequencer and
   // is also the input ready, so a pixel enters exactly when the pipe moves.
   logic          pipe_en;
   logic          win_valid, sort_valid;
   win_type       win;
   item_ctrl_type win_ctrl, sort_ctrl;
   pix_type       sort_med;

   assign req_chan.ready = pipe_en;

   // Position tracking, the two line RAMs (read on accept, written when the pipe
   // next moves, with forwarding for a one-column frame) and the window register.
   mf3_line_window u_line_window (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_chan.valid),
      .req_pixel (req_chan.pixel),
      .pipe_en   (pipe_en),
      .win_valid (win_valid),
      .win       (win),
      .win_ctrl  (win_ctrl)
   );

   // The median is computed for every window; the sequencer zeroes it on the
   // border.
   mf3_median_sort u_median_sort (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (win_valid),
      .win       (win),
      .in_ctrl   (win_ctrl),
      .out_valid (sort_valid),
      .med       (sort_med),
      .out_ctrl  (sort_ctrl)
   );

   mf3_result_seq u_result_seq (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (sort_valid),
      .in_med        (sort_med),
      .in_ctrl       (sort_ctrl),
      .pipe_en       (pipe_en),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_median    (rsp_chan.median),
      .rsp_out_col   (rsp_chan.out_col),
      .rsp_out_row   (rsp_chan.out_row),
      .rsp_last      (rsp_chan.last),
      .rsp_frame_end (rsp_chan.frame_end)
   );
endmodule

/* bench/tb_median_filter_3x3.sv */
// Self-checking bench for median_filter_3x3: a directed table and random small
// frames; results are checked against typed table entries or a behavioral filter model.
// Depends on mf3_pkg, mf3_req_if, mf3_rsp_if and the median_filter_3x3 RTL.
module tb_median_filter_3x3;
   import mf3_pkg::*;

   // The two register indexes past the end of the register list. Writes to
   // them must be ignored and must not restart the frame.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_3 = CSR_INDEX_BITS'(3);

   localparam int RANDOM_PIXELS = 90;     // random items after the directed table
   localparam int STEADY_PIXELS = 40;     // first random items run with no idling
   localparam int SETTLE_CYCLES = 20;     // pipeline is six deep; this covers it
   localparam int DRAIN_LIMIT   = 5000;   // cycles to wait for late results

   // One result item as the filter should send it.
   typedef struct packed {
      pix_type             median;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      logic                last;
      logic                frame_end;
   } result_type;

   // How the results of one pixel are expected: from the model, none at all,
   // or one result typed into the table.
   typedef enum {BY_PREDICTOR, NO_RESULT, ONE_TYPED} check_kind_type;
   typedef enum {STEP_PIXEL, STEP_CSR} step_kind_type;
   typedef enum {MIX_UNIFORM, MIX_EXTREME, MIX_CLUSTER} pixel_mix_type;

   // One row of the directed table: either a register write or a pixel.
   typedef struct {
      step_kind_type             kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      check_kind_type            how;
      result_type                typed;
   } step_type;

   // The only result of a 1x1 frame: a border zero that is also the frame end.
   localparam result_type LONE_PIXEL = '{median: '0, col: '0, row: '0,
                                         last: 1'b1, frame_end: 1'b1};
   // Top-left corner of a 3x3 frame, given alone by the pixel at (1,1).
   localparam result_type TOP_LEFT = '{median: '0, col: '0, row: '0,
                                       last: 1'b1, frame_end: 1'b0};

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   mf3_req_if req_chan();
   mf3_rsp_if rsp_chan();

   median_filter_3x3 DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model of the filter. The two line copies hold the rows above the current
   // one; the neighborhood holds the last three columns, oldest first, each
   // column ordered top to bottom. Positions are those of the next pixel.
   pix_type                   line_above  [MAX_WIDTH];
   pix_type                   line_above2 [MAX_WIDTH];
   win_type                   nbhd;
   int unsigned               col_pos;
   int unsigned               row_pos;
   logic [WIDTH_REG_BITS-1:0] width_reg  = WIDTH_REG_BITS'(RESET_WIDTH);
   logic [ROW_BITS-1:0]       height_reg = ROW_BITS'(RESET_HEIGHT);

   result_type  caused[$];           // results of the pixel just accepted
   result_type  pending_results[$];  // results still owed by the filter, oldest first
   result_type  oldest;
   step_type    script[$];
   int unsigned pixels_sent;
   int unsigned results_checked;
   int unsigned interior_count;
   int unsigned shapes_used;
   int unsigned mismatches;
   bit          steady;              // while set, neither side idles

   // A width of zero acts as one, and anything past the line length is clamped.
   function automatic int unsigned active_width();
      if (width_reg == '0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      return (height_reg == '0) ? 1 : height_reg;
   endfunction

   function automatic void add_result(input pix_type value, input int unsigned col,
                                      input int unsigned row);
      result_type r;
      r.median    = value;
      r.col       = COL_BITS'(col);
      r.row       = ROW_BITS'(row);
      r.last      = 1'b0;
      r.frame_end = 1'b0;
      caused.push_back(r);
   endfunction

   // Advances the model by one pixel and leaves the results it causes in
   // caused. The pixel at (x,y) closes the window centered on (x-1,y-1); row
   // ends add the right border pixel, and the last row adds its own zeros.
   function automatic void predict_medians(input pix_type px);
      int unsigned w, h, x, y, i, j, below, up_to;
      bit          row_end, last_row;
      pix_type     vals[9];
      pix_type     mid;
      w        = active_width();
      h        = active_height();
      x        = col_pos;
      y        = row_pos;
      row_end  = (x + 1 >= w);
      last_row = (y + 1 >= h);
      caused.delete();

      nbhd[0]    = nbhd[1];
      nbhd[1]    = nbhd[2];
      nbhd[2][0] = line_above2[x];
      nbhd[2][1] = line_above[x];
      nbhd[2][2] = px;
      line_above2[x] = line_above[x];
      line_above[x]  = px;

      if (y >= 1) begin
         if (x >= 1) begin
            mid = '0;
            // Only a center that is off every border gets a real median.
            if (x >= 2 && x + 1 <= w && y >= 2 && y + 1 <= h) begin
               for (i = 0; i < 9; i++) vals[i] = nbhd[i / 3][i % 3];
               // The median is the value with at most four below it and at
               // least five at or below it; this holds for ties as well.
               for (i = 0; i < 9; i++) begin
                  below = 0;
                  up_to = 0;
                  for (j = 0; j < 9; j++) begin
                     if (vals[j] < vals[i]) below++;
                     if (vals[j] <= vals[i]) up_to++;
                  end
                  if (below <= 4 && up_to >= 5) mid = vals[i];
               end
               interior_count++;
            end
            add_result(mid, x - 1, y - 1);
         end
         if (row_end) add_result('0, w - 1, y - 1);
      end
      if (last_row) begin
         if (x >= 1) add_result('0, x - 1, y);
         if (row_end) add_result('0, w - 1, y);
      end
      if (caused.size() != 0) begin
         caused[caused.size() - 1].last      = 1'b1;
         caused[caused.size() - 1].frame_end = row_end && last_row;
      end

      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endfunction

   function automatic pix_type random_pixel(input pixel_mix_type mix, input pix_type base);
      case (mix)
         MIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
         MIX_CLUSTER: return base ^ pix_type'($urandom_range(3));
         default:     return pix_type'($urandom_range(255));
      endcase
   endfunction

   function automatic step_type pixel_row(input pix_type px, input check_kind_type how,
                                          input result_type typed);
      step_type s;
      s.kind  = STEP_PIXEL;
      s.index = REG_IMAGE_WIDTH;
      s.data  = CSR_DATA_BITS'(px);
      s.how   = how;
      s.typed = typed;
      return s;
   endfunction

   function automatic step_type csr_row(input logic [CSR_INDEX_BITS-1:0] index,
                                        input logic [CSR_DATA_BITS-1:0] data);
      step_type s;
      s.kind  = STEP_CSR;
      s.index = index;
      s.data  = data;
      s.how   = NO_RESULT;
      s.typed = '0;
      return s;
   endfunction

   function automatic void note_mismatch(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
   endfunction

   // Waits until the filter owes nothing and its pipeline has emptied, so a
   // register may be written or the run may end. Results that never come are
   // failures; they are dropped so that the run can go on.
   task automatic drain();
      int unsigned waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatches += pending_results.size();
         pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only on an idle filter. Any write to a real
   // register restarts the frame; the line stores keep what they hold.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == REG_IMAGE_WIDTH) begin
         width_reg = data[WIDTH_REG_BITS-1:0];
         shapes_used++;
      end else if (index == REG_IMAGE_HEIGHT) begin
         height_reg = data;
      end
      if (index == REG_IMAGE_WIDTH || index == REG_IMAGE_HEIGHT) begin
         nbhd    = '0;
         col_pos = 0;
         row_pos = 0;
      end
      @(posedge clock);
   endtask

   // Offers one pixel item, with an occasional idle gap in front of it, and
   // records what it should cause once the filter has taken it. Valid stays
   // high into the next item when no gap follows.
   task automatic send_pixel(input pix_type px, input check_kind_type how,
                             input result_type typed);
      while (!steady && $urandom_range(99) < 7) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= px;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_medians(px);
      case (how)
         BY_PREDICTOR: foreach (caused[i]) pending_results.push_back(caused[i]);
         ONE_TYPED:    pending_results.push_back(typed);
         default:      ;
      endcase
      pixels_sent++;
   endtask

   // Result side: takes items with random back-pressure and checks each one
   // against the oldest outstanding expectation, field by field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $error("result at col %0d row %0d arrived with nothing expected",
                      rsp_chan.out_col, rsp_chan.out_row);
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_chan.median !== oldest.median)
                  note_mismatch("median", 32'(oldest.median), 32'(rsp_chan.median));
               if (rsp_chan.out_col !== oldest.col)
                  note_mismatch("out_col", 32'(oldest.col), 32'(rsp_chan.out_col));
               if (rsp_chan.out_row !== oldest.row)
                  note_mismatch("out_row", 32'(oldest.row), 32'(rsp_chan.out_row));
               if (rsp_chan.last !== oldest.last)
                  note_mismatch("last", 32'(oldest.last), 32'(rsp_chan.last));
               if (rsp_chan.frame_end !== oldest.frame_end)
                  note_mismatch("frame_end", 32'(oldest.frame_end),
                                32'(rsp_chan.frame_end));
            end
            results_checked++;
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 7);
      end
   end

   initial begin : stimulus
      int unsigned   wval, hval, frame_len, random_pixels;
      pixel_mix_type mix;
      pix_type       base;

      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= REG_IMAGE_WIDTH;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.pixel <= '0;
      steady         <= 1'b0;
      foreach (line_above[i]) begin
         line_above[i]  = '0;
         line_above2[i] = '0;
      end
      nbhd            = '0;
      col_pos         = 0;
      row_pos         = 0;
      pixels_sent     = 0;
      results_checked = 0;
      interior_count  = 0;
      shapes_used     = 0;
      mismatches      = 0;
      random_pixels   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Straight after reset the frame is 640x480, so the first
      // pixels of row zero cause nothing. The 1x1 frames, including the ones
      // set by zero-valued registers, give one border zero per pixel that is
      // also the frame end. The 3x3 frame has a single interior pixel; its last
      // pixel causes the most results any pixel can. The spare-index writes in
      // the middle of that frame must leave it running.
      script = {
         pixel_row(8'hFF, NO_RESULT, '0),
         pixel_row(8'h00, NO_RESULT, '0),
         csr_row(REG_IMAGE_WIDTH, 16'd1),
         csr_row(REG_IMAGE_HEIGHT, 16'd1),
         pixel_row(8'hFF, ONE_TYPED, LONE_PIXEL),
         pixel_row(8'h00, ONE_TYPED, LONE_PIXEL),
         csr_row(REG_IMAGE_WIDTH, 16'd0),
         csr_row(REG_IMAGE_HEIGHT, 16'd0),
         pixel_row(8'h5A, ONE_TYPED, LONE_PIXEL),
         csr_row(REG_IMAGE_WIDTH, 16'hF003),
         csr_row(REG_IMAGE_HEIGHT, 16'd3),
         pixel_row(8'h10, NO_RESULT, '0),
         pixel_row(8'hFF, NO_RESULT, '0),
         pixel_row(8'h00, NO_RESULT, '0),
         pixel_row(8'h80, NO_RESULT, '0),
         csr_row(REG_SPARE_2, 16'hFFFF),
         csr_row(REG_SPARE_3, 16'd1),
         pixel_row(8'hFF, ONE_TYPED, TOP_LEFT),
         pixel_row(8'h7F, BY_PREDICTOR, '0),
         pixel_row(8'h00, NO_RESULT, '0),
         pixel_row(8'h01, BY_PREDICTOR, '0),
         pixel_row(8'hFE, BY_PREDICTOR, '0)
      };
      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            write_csr(script[i].index, script[i].data);
         end else begin
            send_pixel(script[i].data[PIX_BITS-1:0], script[i].how, script[i].typed);
         end
      end

      // Random part: small frames of random shape, mostly whole frames (some
      // run twice so the frame wraps onto old line contents), a few cut short
      // by the next register write. Width writes carry junk in the unused high
      // bits. Pixel mixes are picked at random from uniform, only the extremes, and a
      // tight cluster that forces ties in the sort. The first frames run with
      // neither side idling.
      while (random_pixels < RANDOM_PIXELS) begin
         steady <= (random_pixels < STEADY_PIXELS);
         wval = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         write_csr(REG_IMAGE_WIDTH, {4'($urandom), WIDTH_REG_BITS'(wval)});
         hval = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
         write_csr(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(hval));
         if ($urandom_range(4) == 0)
            write_csr($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                      CSR_DATA_BITS'($urandom));
         frame_len = active_width() * active_height() * $urandom_range(1, 2);
         if ($urandom_range(5) == 0) frame_len = $urandom_range(1, frame_len);
         if (frame_len > RANDOM_PIXELS - random_pixels)
            frame_len = RANDOM_PIXELS - random_pixels;
         mix  = pixel_mix_type'($urandom_range(2));
         base = pix_type'($urandom_range(255));
         repeat (frame_len) begin
            send_pixel(random_pixel(mix, base), BY_PREDICTOR, '0);
            random_pixels++;
         end
      end
      steady <= 1'b0;

      drain();
      $display("Sent %0d pixel items over %0d frame shapes from 1x1 up to 8x6, with",
               pixels_sent, shapes_used);
      $display("zero and spare register writes; checked %0d results, %0d interior medians.",
               results_checked, interior_count);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $error("run did not finish within the time limit");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
rtl/mf3_pkg.sv
rtl/mf3_req_if.sv
rtl/mf3_rsp_if.sv
rtl/mf3_ram.sv
rtl/mf3_line_window.sv
rtl/mf3_median_sort.sv
rtl/mf3_result_seq.sv
rtl/median_filter_3x3.sv
bench/tb_median_filter_3x3.sv
